[hdl/msd_pkg.sv]
// Shared types and constants for the mean and standard deviation block.
// No dependencies; imported by every module under hdl.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

	localparam int SAMPLE_W      = 24;            // Q12.12 sample and mean
	localparam int COUNT_OUT_W   = 11;            // reported count width
	localparam int SQ_BASE_W     = 2 * SAMPLE_W;  // one squared difference
	localparam int ROOT_W        = SQ_BASE_W / 2; // deviation width
	localparam int DEF_MAX_ITEMS = 1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_MEAN,
		ST_PASS,
		ST_DIV_VAR,
		ST_SQRT,
		ST_OUT
	} msd_state_t;

	// Handshake status reported by the iterative units
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

[hdl/msd_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on msd_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module msd_div #(
	parameter int DIVD_W = 59,
	parameter int DIVS_W = 11
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [DIVD_W-1:0]          dividend,
	input  wire logic [DIVS_W-1:0]          divisor,
	output msd_pkg::unit_stat_t             stat,
	output logic [DIVD_W-1:0]               quotient
);
	import msd_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] dq_q;
	logic [DIVS_W-1:0] rem_q;

	logic [DIVS_W:0]   rem_shift;
	logic [DIVS_W:0]   rem_diff;
	logic              fits;

	always_comb begin
		rem_shift = {rem_q, dq_q[DIVD_W-1]};
		rem_diff  = rem_shift - {1'b0, divisor};
		fits      = rem_shift >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend bits out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (go) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dq_q  <= {dq_q[DIVD_W-2:0], fits};
			rem_q <= fits ? rem_diff[DIVS_W-1:0] : rem_shift[DIVS_W-1:0];
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;

endmodule

`default_nettype wire

[hdl/msd_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on msd_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module msd_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [msd_pkg::SQ_BASE_W-1:0] radicand,
	output msd_pkg::unit_stat_t               stat,
	output logic [msd_pkg::ROOT_W-1:0]        root
);
	import msd_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int REM_W = ROOT_W + 2;

	logic                 run_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SQ_BASE_W-1:0] rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;

	logic [REM_W+1:0]     rem_shift;
	logic [REM_W+1:0]     trial;
	logic [REM_W+1:0]     rem_diff;
	logic                 fits;

	always_comb begin
		rem_shift = {rem_q, rad_q[SQ_BASE_W-1 -: 2]};
		trial     = {2'b00, root_q, 2'b01};
		rem_diff  = rem_shift - trial;
		fits      = rem_shift >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Bring in two radicand bits per step, decide one root bit
	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[SQ_BASE_W-3:0], 2'b00};
			rem_q  <= fits ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

`default_nettype wire

[hdl/mean_and_std_deviation.sv]
// Top level: sample store, load path, second pass and the sequencer that
// drives the shared divider and the square root unit.
// Depends on msd_pkg, msd_div and msd_sqrt.
//
// Usage
//   Present an item (sample, last_of_set) with start high while busy is low;
//   it is taken at that clock edge. Loading takes one item per cycle: busy
//   stays low between samples of a set. A sample that arrives with the store
//   full (MAX_ITEMS held) is dropped and sets the overflow flag; a dropped
//   item that carries last_of_set still closes the set.
//   The closing item raises busy. The sequencer then runs:
//     a prep step, the mean division (DIV_W = 48 + clog2(MAX_ITEMS+1)
//     quotient bits, DIV_W = 59 at the default depth), a pass over the
//     store (one read per cycle from the store read port), the variance
//     division and the square root, then an output step.
//   done is high for exactly one cycle with mean_value, std_deviation,
//   sample_count and overflowed valid; the receiver cannot stall it. The
//   next set's first item may start the cycle after done.
//   Reset clears the sequencer, running sum, count and overflow flag; the
//   store is not cleared, only entries written in the current set are read.
`timescale 1ns / 1ps
`default_nettype none

module mean_and_std_deviation #(
	parameter int MAX_ITEMS = msd_pkg::DEF_MAX_ITEMS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [msd_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                last_of_set,
	output logic                                     done,
	output logic signed [msd_pkg::SAMPLE_W-1:0]      mean_value,
	output logic [msd_pkg::ROOT_W-1:0]               std_deviation,
	output logic [msd_pkg::COUNT_OUT_W-1:0]          sample_count,
	output logic                                     overflowed
);
	import msd_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);   // holds 0..MAX_ITEMS
	localparam int IDX_W = $clog2(MAX_ITEMS);       // store address
	localparam int SUM_W = SAMPLE_W + CNT_W;        // running sum, signed
	localparam int SQ_W  = SQ_BASE_W + CNT_W;       // sum of squares

	msd_state_t state_q, state_d;

	// Set state
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           held_q;
	logic                       dropped_q;

	// Second pass
	logic [CNT_W-1:0]           rd_q;
	logic [SAMPLE_W-1:0]        rdata_s1;
	logic                       vld_s1;
	logic [SQ_BASE_W-1:0]       sq_s2;
	logic                       vld_s2;
	logic [SQ_W-1:0]            sumsq_q;

	// Results
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [ROOT_W-1:0]          std_q;
	logic                       neg_q;

	logic [SAMPLE_W-1:0]        store_mem [MAX_ITEMS];

	logic                       accept;
	logic                       full;
	logic                       wr_en;
	logic                       issue;
	logic                       pass_end;
	logic                       div_go;
	logic                       sqrt_go;
	logic [SUM_W-1:0]           sum_abs;
	logic [SQ_W-1:0]            div_dividend;
	logic [SQ_W-1:0]            div_quot;
	logic [ROOT_W-1:0]          sqrt_root;
	logic [SAMPLE_W-1:0]        mean_mag;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [2*SAMPLE_W+1:0] prod;
	unit_stat_t                 div_st;
	unit_stat_t                 sqrt_st;

	assign accept   = start && (state_q == ST_IDLE);
	assign full     = (held_q == CNT_W'(MAX_ITEMS));
	assign wr_en    = accept && !full;
	assign issue    = (state_q == ST_PASS) && (rd_q != held_q);
	assign pass_end = (state_q == ST_PASS) && (rd_q == held_q) && !vld_s1 && !vld_s2;

	// Magnitude of the sum; the divider works unsigned, sign comes back later
	assign sum_abs      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_dividend = (state_q == ST_PREP) ? SQ_W'(sum_abs) : sumsq_q;
	assign mean_mag     = div_quot[SAMPLE_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept && last_of_set) state_d = ST_PREP;
			ST_PREP:     state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: if (div_st.done) state_d = ST_PASS;
			ST_PASS:     if (pass_end) state_d = ST_DIV_VAR;
			ST_DIV_VAR:  if (div_st.done) state_d = ST_SQRT;
			ST_SQRT:     if (sqrt_st.done) state_d = ST_OUT;
			ST_OUT:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: unit launches, handshake
	always_comb begin
		div_go  = 1'b0;
		sqrt_go = 1'b0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE:     busy = 1'b0;
			ST_PREP:     div_go = 1'b1;
			ST_DIV_MEAN: ;
			ST_PASS:     div_go = pass_end;
			ST_DIV_VAR:  sqrt_go = div_st.done;
			ST_SQRT:     ;
			ST_OUT:      done = 1'b1;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			held_q    <= '0;
			dropped_q <= 1'b0;
			rd_q      <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			sumsq_q   <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			vld_s2  <= vld_s1;
			if (accept) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					sum_q  <= sum_q + SUM_W'(sample);
					held_q <= held_q + 1'b1;
				end
			end
			// Arm the pass in the prep state, as the mean division is launched
			if (state_q == ST_PREP) begin
				rd_q    <= '0;
				sumsq_q <= '0;
			end
			if (issue) rd_q <= rd_q + 1'b1;
			if (vld_s2) sumsq_q <= sumsq_q + SQ_W'(sq_s2);
			// Drop the set state once the result is out
			if (state_q == ST_OUT) begin
				sum_q     <= '0;
				held_q    <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	// Sample store: write while loading, registered read during the pass
	always_ff @(posedge clk) begin
		if (wr_en) store_mem[held_q[IDX_W-1:0]] <= sample;
		rdata_s1 <= store_mem[rd_q[IDX_W-1:0]];
	end

	// Difference from the truncated mean, squared; register the product
	assign diff = $signed({rdata_s1[SAMPLE_W-1], rdata_s1}) - $signed({mean_q[SAMPLE_W-1], mean_q});
	assign prod = diff * diff;

	always_ff @(posedge clk) begin
		sq_s2 <= prod[SQ_BASE_W-1:0];
		if (state_q == ST_PREP) neg_q <= sum_q[SUM_W-1];
		// Restore the sign: the quotient magnitude truncates toward zero
		if ((state_q == ST_DIV_MEAN) && div_st.done) begin
			mean_q <= neg_q ? $signed(-mean_mag) : $signed(mean_mag);
		end
		if ((state_q == ST_SQRT) && sqrt_st.done) std_q <= sqrt_root;
	end

	msd_div #(
		.DIVD_W (SQ_W),
		.DIVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (held_q),
		.stat     (div_st),
		.quotient (div_quot)
	);

	msd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sqrt_go),
		.radicand (div_quot[SQ_BASE_W-1:0]),
		.stat     (sqrt_st),
		.root     (sqrt_root)
	);

	assign mean_value    = mean_q;
	assign std_deviation = std_q;
	assign sample_count  = COUNT_OUT_W'(held_q);
	assign overflowed    = dropped_q;

	// The fill count never passes the store depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(MAX_ITEMS))
		else $error("sample count beyond store depth");

	// A closing item makes the block busy on the next cycle
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_of_set) |=> busy)
		else $error("closing item did not start the computation");

	// After the result strobe the block is ready again with an empty set
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && held_q == '0 && !overflowed))
		else $error("set state not cleared after result");

	// Divider completions only occur in the division states
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV_MEAN || state_q == ST_DIV_VAR))
		else $error("divider finished outside a division state");

	// No unit is launched while it is still working
	a_no_relaunch: assert property (@(posedge clk) disable iff (!arst_n)
		(div_go |-> !div_st.busy) and (sqrt_go |-> !sqrt_st.busy))
		else $error("unit launched while busy");

endmodule

`default_nettype wire
